@@ rtl/core/nfc_pkg.sv @@
package nfc_pkg;

  typedef enum logic [2:0] {
    OP_F32_F16_CLAMP = 3'd0,
    OP_F32_F16       = 3'd1,
    OP_F32_I8        = 3'd2,
    OP_F16_F32       = 3'd3,
    OP_F16_I8        = 3'd4,
    OP_BF16_F16_CLAMP = 3'd5,
    OP_BF16_F32      = 3'd6,
    OP_U8_F16        = 3'd7
  } op_e;

  localparam logic [31:0] F16_MAX_AS_F32    = 32'h477F_E000;
  localparam logic [31:0] F16_LOWEST_AS_F32 = 32'hC77F_E000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] src;
  } item_t;

  // f32 to f16, round to nearest even, f16 subnormal results kept, f32 subnormal inputs flushed to signed zero
  function automatic logic [15:0] f32_to_f16(input logic [31:0] b);
    logic [15:0] sign;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [15:0] h;
    logic [12:0] r;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [23:0] q;
    logic [23:0] rem;
    logic [23:0] half;
    sign = {b[31], 15'd0};
    ex   = b[30:23];
    man  = b[22:0];
    f32_to_f16 = sign;
    if (ex == 8'hFF) begin
      if (man != 23'd0) f32_to_f16 = sign | 16'h7E00 | {6'd0, man[22:13]};
      else f32_to_f16 = sign | 16'h7C00;
    end else if (ex == 8'd0) begin
      f32_to_f16 = sign;
    end else if (ex >= 8'd143) begin
      f32_to_f16 = sign | 16'h7C00;
    end else if (ex >= 8'd113) begin
      h = {1'b0, 5'(ex - 8'd112), man[22:13]};
      r = man[12:0];
      if (r > 13'h1000 || (r == 13'h1000 && h[0])) h = h + 16'd1;
      f32_to_f16 = sign | h;
    end else if (ex >= 8'd102) begin
      // shift of 14..24 for subnormal results
      full = {1'b1, man};
      sh   = 5'(8'd126 - ex);
      q    = full >> sh;
      rem  = full & ((24'd1 << sh) - 24'd1);
      half = 24'd1 << (sh - 5'd1);
      if (rem > half || (rem == half && q[0])) q = q + 24'd1;
      f32_to_f16 = sign | q[15:0];
    end
  endfunction

  function automatic logic [31:0] f16_to_f32(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic [10:0] norm;
    sign = {h[15], 31'd0};
    ex   = h[14:10];
    man  = h[9:0];
    lz   = 4'd0;
    for (int i = 0; i < 10; i++) if (man[i]) lz = 4'(9 - i);
    norm = {1'b0, man} << (lz + 4'd1);
    if (ex == 5'h1F) begin
      if (man != 10'd0) f16_to_f32 = sign | 32'h7FC0_0000 | {9'd0, man, 13'd0};
      else f16_to_f32 = sign | 32'h7F80_0000;
    end else if (ex == 5'd0) begin
      if (man == 10'd0) f16_to_f32 = sign;
      else f16_to_f32 = sign | {1'b0, 8'(8'd112 - {4'd0, lz}), norm[9:0], 13'd0};
    end else begin
      f16_to_f32 = sign | {1'b0, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
  endfunction

  // truncate toward zero to i32, keep low byte
  function automatic logic [7:0] f32_trunc_i8(input logic [31:0] b);
    logic [7:0]  ex;
    logic [23:0] full;
    logic [31:0] mag;
    logic [31:0] v;
    ex   = b[30:23];
    full = {1'b1, b[22:0]};
    mag  = 32'd0;
    if (ex >= 8'd127 && ex <= 8'd150) mag = {8'd0, full} >> 5'(8'd150 - ex);
    else if (ex > 8'd150 && ex < 8'd158) mag = {8'd0, full} << 5'(ex - 8'd150);
    v = b[31] ? (32'd0 - mag) : mag;
    if (ex == 8'hFF || ex >= 8'd158) v = 32'h8000_0000;
    f32_trunc_i8 = v[7:0];
  endfunction

  function automatic logic [15:0] u8_to_f16(input logic [7:0] n);
    logic [2:0]  p;
    logic [17:0] s;
    p = 3'd0;
    for (int i = 0; i < 8; i++) if (n[i]) p = 3'(i);
    s = {10'd0, n} << (4'd10 - {1'b0, p});
    u8_to_f16 = (n == 8'd0) ? 16'd0 : {1'b0, 5'({2'd0, p} + 5'd15), s[9:0]};
  endfunction

  function automatic logic [31:0] clamp_f16_range(input logic [31:0] b);
    clamp_f16_range = b;
    if (b[30:0] > 31'h7F80_0000) clamp_f16_range = F16_LOWEST_AS_F32;
    else if (b[30:0] > F16_MAX_AS_F32[30:0])
      clamp_f16_range = {b[31], F16_MAX_AS_F32[30:0]};
  endfunction

endpackage

@@ rtl/core/nfc_convert.sv @@
module nfc_convert (
  input  nfc_pkg::item_t item_i,
  output logic [31:0]    result_o
);
  import nfc_pkg::*;

  logic [15:0] lo16;
  logic [31:0] wide16;

  assign lo16   = item_i.src[15:0];
  assign wide16 = f16_to_f32(lo16);

  always_comb begin
    case (op_e'(item_i.op))
      OP_F32_F16_CLAMP:  result_o = {16'd0, f32_to_f16(clamp_f16_range(item_i.src))};
      OP_F32_F16:        result_o = {16'd0, f32_to_f16(item_i.src)};
      OP_F32_I8:         result_o = {24'd0, f32_trunc_i8(item_i.src)};
      OP_F16_F32:        result_o = wide16;
      OP_F16_I8:         result_o = {24'd0, f32_trunc_i8(wide16)};
      OP_BF16_F16_CLAMP: result_o = {16'd0, f32_to_f16(clamp_f16_range({lo16, 16'd0}))};
      OP_BF16_F32:       result_o = {lo16, 16'd0};
      OP_U8_F16:         result_o = {16'd0, u8_to_f16(item_i.src[7:0])};
      default:           result_o = 32'd0;
    endcase
  end
endmodule

@@ rtl/core/numeric_format_converter.sv @@
// path: input register, then result register, from input transaction to result
// throughput: one transaction per cycle while the output is not stalled, set by the single conversion stage
// reset: rst_ni asynchronous active low clears valid flags; data registers not reset
// a stalled result holds; the input stage advances whenever the result stage can take it
module numeric_format_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] source_bits
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] result_bits
);
  import nfc_pkg::*;

  item_t       in_q;
  logic        in_vld_q;
  logic [31:0] res_d, res_q;
  logic        res_vld_q;
  logic        res_ready;

  // result stage frees up when empty or being drained
  assign res_ready     = !res_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= '{op: s_axis_tuser, src: s_axis_tdata};
    end
  end

  nfc_convert u_convert (
    .item_i  (in_q),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_ready) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = res_q;
endmodule

@@ rtl/core/nfc_checker.sv @@
module nfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  // stalled result holds its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // an idle output side never blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // accepted input shows up as a result, through the input and result registers, when output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after latency");
endmodule

bind numeric_format_converter nfc_checker u_nfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
